>>> hw/rtl/bde_pkg.sv
// Package for the bounded deque engine: op codes, data width and default depth.
// No dependencies; imported by bde_mod, bounded_deque_engine and the testbench.
package bde_pkg;

	localparam int DATA_W        = 32;
	localparam int DEPTH_DEFAULT = 16;

	localparam logic [3:0] OP_ADD_BACK   = 4'd0;
	localparam logic [3:0] OP_ADD_FRONT  = 4'd1;
	localparam logic [3:0] OP_TAKE_BACK  = 4'd2;
	localparam logic [3:0] OP_TAKE_FRONT = 4'd3;
	localparam logic [3:0] OP_PEEK_BACK  = 4'd4;
	localparam logic [3:0] OP_PEEK_FRONT = 4'd5;
	localparam logic [3:0] OP_CLEAR      = 4'd6;
	localparam logic [3:0] OP_CONTAINS   = 4'd7;
	localparam logic [3:0] OP_REVERSE    = 4'd8;
	localparam logic [3:0] OP_SORT       = 4'd9;
	localparam logic [3:0] OP_SWAP_ENDS  = 4'd10;
	localparam logic [3:0] OP_ROTATE     = 4'd11;
	localparam logic [3:0] OP_READ_ALL   = 4'd12;
	localparam logic [3:0] OP_POP_ALL    = 4'd13;
	localparam logic [3:0] OP_STATUS     = 4'd14;
	localparam logic [3:0] OP_RESERVED   = 4'd15;

endpackage

>>> hw/rtl/bde_ram.sv
// Generic single-write, single-read RAM with registered read data.
// Depends on nothing but its parameters.
module bde_ram #(
	parameter int W = 32,
	parameter int D = 16
) (
	input  logic                 clk,
	input  logic                 we,
	input  logic [$clog2(D)-1:0] waddr,
	input  logic [W-1:0]         wdata,
	input  logic [$clog2(D)-1:0] raddr,
	output logic [W-1:0]         rdata
);

	logic [W-1:0] mem [D];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

>>> hw/rtl/bde_mod.sv
// Bit-serial restoring remainder unit: num mod den, one dividend bit a cycle.
// Depends on bde_pkg for the data width.
module bde_mod import bde_pkg::*; #(
	parameter int CW = 5
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DATA_W-1:0] num,
	input  logic [CW-1:0]     den,
	output logic              done,
	output logic [CW-1:0]     rem
);

	localparam int SW = $clog2(DATA_W);

	logic              run_q;
	logic              done_q;
	logic [SW-1:0]     cnt_q;
	logic [DATA_W-1:0] num_q;
	logic [CW-1:0]     den_q;
	logic [CW-1:0]     rem_q;
	logic [CW:0]       trial;
	logic [CW:0]       nxt;

	always_comb begin
		trial = {rem_q, num_q[DATA_W-1]};
		if (trial >= {1'b0, den_q}) begin
			nxt = trial - {1'b0, den_q};
		end else begin
			nxt = trial;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			run_q  <= 1'b1;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else if (run_q) begin
			cnt_q <= cnt_q + 1'b1;
			if (cnt_q == SW'(DATA_W - 1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end else begin
			done_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			num_q <= num;
			den_q <= den;
			rem_q <= '0;
		end else if (run_q) begin
			num_q <= num_q << 1;
			rem_q <= nxt[CW-1:0];
		end
	end

	assign done = done_q;
	assign rem  = rem_q;

endmodule

>>> hw/rtl/bounded_deque_engine.sv
// Bounded deque engine: ring buffer in a RAM, walked by a small sequencer.
// Pop/peek read the end element, contains/read_all/pop_all scan the elements, reverse
// and swap read and write back pairs, sort does (n-1)^2 neighbor compares and rotate
// reduces its amount in the remainder unit first. One item at a time (busy).
// Results are strobed for one cycle each; the receiver cannot stall them.
// arst_n clears count, head and sequencer; stored values are undefined until written.
module bounded_deque_engine import bde_pkg::*; #(
	parameter int DEPTH = DEPTH_DEFAULT
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [3:0]                  op,
	input  logic signed [DATA_W-1:0]    data_in,
	input  logic signed [DATA_W-1:0]    rotate_by,
	input  logic                        ascending,
	output logic                        result_valid,
	output logic signed [DATA_W-1:0]    data_out,
	output logic                        data_valid,
	output logic                        found,
	output logic                        push_dropped,
	output logic [$clog2(DEPTH+1)-1:0]  count,
	output logic                        is_empty,
	output logic                        is_full,
	output logic                        last
);

	localparam int AW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH+1);

	// Sequencer states.
	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_POP  = 4'd1;  // wait for the end element
	localparam logic [3:0] S_SCR  = 4'd2;  // scan: issue read
	localparam logic [3:0] S_SCC  = 4'd3;  // scan: consume element
	localparam logic [3:0] S_PA   = 4'd4;  // pair: read first
	localparam logic [3:0] S_PB   = 4'd5;  // pair: read second, hold first
	localparam logic [3:0] S_PC   = 4'd6;  // pair: compare, write first
	localparam logic [3:0] S_PD   = 4'd7;  // pair: write second
	localparam logic [3:0] S_DIV  = 4'd8;  // rotate amount modulo count
	localparam logic [3:0] S_RTR  = 4'd9;  // rotate: read front
	localparam logic [3:0] S_RTW  = 4'd10; // rotate: append front at back

	logic [3:0]        state_q, state_d;
	logic [AW-1:0]     head_q, head_d;
	logic [CW-1:0]     count_q, count_d;
	logic [CW-1:0]     i_q, i_d;
	logic [CW-1:0]     p_q, p_d;
	logic              found_q, found_d;
	logic [3:0]        op_q;
	logic [DATA_W-1:0] din_q;
	logic              asc_q;
	logic              neg_q;
	logic [DATA_W-1:0] a_q;

	logic              ram_we;
	logic [AW-1:0]     ram_waddr, ram_raddr;
	logic [DATA_W-1:0] ram_wdata, ram_rdata;

	logic              mod_start, mod_done;
	logic [CW-1:0]     mod_rem;
	logic [DATA_W-1:0] rot_mag;

	logic              e_en, e_dv, e_found, e_drop, e_last;
	logic [DATA_W-1:0] e_data;
	logic [CW-1:0]     e_cnt;

	logic [AW-1:0]     addr_a, addr_b, head_inc, head_dec;
	logic [CW-1:0]     pr_i, pr_p, sh;
	logic              pr_fin, do_swap, scan_last, hit;

	// Physical slot of logical position off.
	function automatic logic [AW-1:0] slot(input logic [AW-1:0] h, input logic [CW-1:0] off);
		logic [CW:0] s;
		s = (CW+1)'(h) + (CW+1)'(off);
		if (s >= (CW+1)'(DEPTH)) s = s - (CW+1)'(DEPTH);
		return s[AW-1:0];
	endfunction

	bde_ram #(.W(DATA_W), .D(DEPTH)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign rot_mag = rotate_by[DATA_W-1] ? DATA_W'(-rotate_by) : DATA_W'(rotate_by);

	bde_mod #(.CW(CW)) u_mod (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mod_start),
		.num    (rot_mag),
		.den    (count_q),
		.done   (mod_done),
		.rem    (mod_rem)
	);

	assign head_inc = (head_q == AW'(DEPTH-1)) ? '0 : head_q + 1'b1;
	assign head_dec = (head_q == '0) ? AW'(DEPTH-1) : head_q - 1'b1;

	// Pair addresses: sort walks neighbors, reverse and swap walk inward from both ends.
	assign addr_a = slot(head_q, i_q);
	assign addr_b = (op_q == OP_SORT) ? slot(head_q, i_q + 1'b1)
	                                  : slot(head_q, count_q - 1'b1 - i_q);

	assign do_swap = (op_q != OP_SORT) ? 1'b1 :
	                 asc_q ? ($signed(a_q) > $signed(ram_rdata))
	                       : ($signed(a_q) < $signed(ram_rdata));

	// Advance the pair walk; a sort pass ends at the next-to-last element.
	always_comb begin
		pr_i   = i_q + 1'b1;
		pr_p   = p_q;
		pr_fin = 1'b1;
		case (op_q)
			OP_SORT: begin
				if ((CW+1)'(i_q) + 2'd2 == (CW+1)'(count_q)) begin
					pr_i   = '0;
					pr_p   = p_q + 1'b1;
					pr_fin = ((CW+1)'(p_q) + 2'd2 == (CW+1)'(count_q));
				end else begin
					pr_fin = 1'b0;
				end
			end
			OP_REVERSE: begin
				pr_fin = (i_q + 1'b1 == (count_q >> 1));
			end
			default: begin
				pr_fin = 1'b1;
			end
		endcase
	end

	assign scan_last = (i_q + 1'b1 == count_q);
	assign hit       = (ram_rdata == din_q);
	assign sh        = (neg_q && mod_rem != '0) ? count_q - mod_rem : mod_rem;

	always_comb begin
		state_d   = state_q;
		head_d    = head_q;
		count_d   = count_q;
		i_d       = i_q;
		p_d       = p_q;
		found_d   = found_q;
		ram_we    = 1'b0;
		ram_waddr = addr_a;
		ram_wdata = ram_rdata;
		ram_raddr = addr_a;
		mod_start = 1'b0;
		e_en      = 1'b0;
		e_data    = '0;
		e_dv      = 1'b0;
		e_found   = 1'b0;
		e_drop    = 1'b0;
		e_cnt     = count_q;
		e_last    = 1'b1;
		case (state_q)
			S_IDLE: begin
				i_d     = '0;
				p_d     = '0;
				found_d = 1'b0;
				if (start) begin
					case (op)
						OP_ADD_BACK, OP_ADD_FRONT: begin
							e_en = 1'b1;
							if (count_q == CW'(DEPTH)) begin
								e_drop = 1'b1;
							end else begin
								ram_we    = 1'b1;
								ram_wdata = data_in;
								if (op == OP_ADD_BACK) begin
									ram_waddr = slot(head_q, count_q);
								end else begin
									ram_waddr = head_dec;
									head_d    = head_dec;
								end
								count_d = count_q + 1'b1;
								e_cnt   = count_q + 1'b1;
							end
						end
						OP_TAKE_BACK, OP_TAKE_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
							if (count_q == '0) begin
								e_en = 1'b1;
							end else begin
								ram_raddr = (op == OP_TAKE_BACK || op == OP_PEEK_BACK)
								            ? slot(head_q, count_q - 1'b1) : head_q;
								state_d   = S_POP;
							end
						end
						OP_CLEAR: begin
							count_d = '0;
							e_cnt   = '0;
							e_en    = 1'b1;
						end
						OP_CONTAINS, OP_READ_ALL, OP_POP_ALL: begin
							if (count_q == '0) e_en = 1'b1;
							else state_d = S_SCR;
						end
						OP_REVERSE, OP_SORT, OP_SWAP_ENDS: begin
							if (count_q < CW'(2)) e_en = 1'b1;
							else state_d = S_PA;
						end
						OP_ROTATE: begin
							if (count_q == '0) begin
								e_en = 1'b1;
							end else begin
								mod_start = 1'b1;
								state_d   = S_DIV;
							end
						end
						default: begin
							e_en = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				e_en   = 1'b1;
				e_dv   = 1'b1;
				e_data = ram_rdata;
				state_d = S_IDLE;
				if (op_q == OP_TAKE_BACK || op_q == OP_TAKE_FRONT) begin
					count_d = count_q - 1'b1;
					e_cnt   = count_q - 1'b1;
				end
				if (op_q == OP_TAKE_FRONT) head_d = head_inc;
			end
			S_SCR: begin
				ram_raddr = slot(head_q, i_q);
				state_d   = S_SCC;
			end
			S_SCC: begin
				if (op_q == OP_CONTAINS) begin
					if (scan_last) begin
						e_en    = 1'b1;
						e_found = found_q | hit;
						state_d = S_IDLE;
					end else begin
						found_d = found_q | hit;
						i_d     = i_q + 1'b1;
						state_d = S_SCR;
					end
				end else begin
					// One beat per element; pop-all reports the emptied count throughout.
					e_en   = 1'b1;
					e_dv   = 1'b1;
					e_data = ram_rdata;
					e_last = scan_last;
					if (op_q == OP_POP_ALL) e_cnt = '0;
					if (scan_last) begin
						if (op_q == OP_POP_ALL) count_d = '0;
						state_d = S_IDLE;
					end else begin
						i_d     = i_q + 1'b1;
						state_d = S_SCR;
					end
				end
			end
			S_PA: begin
				ram_raddr = addr_a;
				state_d   = S_PB;
			end
			S_PB: begin
				ram_raddr = addr_b;
				state_d   = S_PC;
			end
			S_PC: begin
				if (do_swap) begin
					ram_we    = 1'b1;
					ram_waddr = addr_a;
					ram_wdata = ram_rdata;
					state_d   = S_PD;
				end else if (pr_fin) begin
					e_en    = 1'b1;
					state_d = S_IDLE;
				end else begin
					i_d     = pr_i;
					p_d     = pr_p;
					state_d = S_PA;
				end
			end
			S_PD: begin
				ram_we    = 1'b1;
				ram_waddr = addr_b;
				ram_wdata = a_q;
				if (pr_fin) begin
					e_en    = 1'b1;
					state_d = S_IDLE;
				end else begin
					i_d     = pr_i;
					p_d     = pr_p;
					state_d = S_PA;
				end
			end
			S_DIV: begin
				if (mod_done) begin
					if (sh == '0) begin
						e_en    = 1'b1;
						state_d = S_IDLE;
					end else begin
						i_d     = sh;
						state_d = S_RTR;
					end
				end
			end
			S_RTR: begin
				ram_raddr = head_q;
				state_d   = S_RTW;
			end
			S_RTW: begin
				// Move the front element to the back and advance the head.
				ram_we    = 1'b1;
				ram_waddr = slot(head_q, count_q);
				ram_wdata = ram_rdata;
				head_d    = head_inc;
				if (i_q == CW'(1)) begin
					e_en    = 1'b1;
					state_d = S_IDLE;
				end else begin
					i_d     = i_q - 1'b1;
					state_d = S_RTR;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			head_q       <= '0;
			count_q      <= '0;
			i_q          <= '0;
			p_q          <= '0;
			found_q      <= 1'b0;
			result_valid <= 1'b0;
		end else begin
			state_q      <= state_d;
			head_q       <= head_d;
			count_q      <= count_d;
			i_q          <= i_d;
			p_q          <= p_d;
			found_q      <= found_d;
			result_valid <= e_en;
		end
	end

	// Payload registers: item fields, pair holding register, result beat.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			op_q  <= op;
			din_q <= data_in;
			asc_q <= ascending;
			neg_q <= rotate_by[DATA_W-1];
		end
		if (state_q == S_PB) a_q <= ram_rdata;
		if (e_en) begin
			data_out     <= e_data;
			data_valid   <= e_dv;
			found        <= e_found;
			push_dropped <= e_drop;
			count        <= e_cnt;
			is_empty     <= (e_cnt == '0);
			is_full      <= (e_cnt == CW'(DEPTH));
			last         <= e_last;
		end
	end

	assign busy = (state_q != S_IDLE);

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("element count above depth");

	a_stream_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !last |-> busy)
		else $error("read-out stream stopped before its last beat");

	a_flags: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (is_empty == (count == '0)) && !(is_empty && is_full))
		else $error("status flags disagree with count");

	a_mod_wait: assert property (@(posedge clk) disable iff (!arst_n)
		mod_done |-> state_q == S_DIV)
		else $error("remainder finished outside rotate");

endmodule

>>> verif/bounded_deque_engine_test.sv
`timescale 1ns / 1ps
// Self-checking testbench for bounded_deque_engine: directed table, then random op mix.
// Depends on bde_pkg and bounded_deque_engine; predicts every result beat in-line.
module bounded_deque_engine_test;
	import bde_pkg::*;

	localparam int DEPTH = DEPTH_DEFAULT;
	localparam int WATCHDOG_LIMIT = 20000;

	typedef struct packed {
		logic signed [31:0] data;
		logic               dvalid;
		logic               fnd;
		logic               dropped;
		logic [4:0]         cnt;
		logic               empty;
		logic               full;
		logic               lst;
	} beat_t;

	typedef struct {
		logic [3:0]  op;
		logic [31:0] din;
		logic [31:0] rot;
		logic        asc;
		bit          typed;   // expected beat typed in below
		beat_t       beat;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [3:0]         op = OP_STATUS;
	logic signed [31:0] data_in = '0;
	logic signed [31:0] rotate_by = '0;
	logic               ascending = 1'b0;
	logic               result_valid;
	logic signed [31:0] data_out;
	logic               data_valid;
	logic               found;
	logic               push_dropped;
	logic [4:0]         count;
	logic               is_empty;
	logic               is_full;
	logic               last;

	bounded_deque_engine #(.DEPTH(DEPTH)) u_dut (.*);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Shadow deque kept in logical order, front at index 0.
	logic [31:0] shadow_q[$];
	beat_t       pending_beats[$];
	int          errors = 0;
	int          idle_cycles = 0;
	int          sender_idle_pct = 0;

	function automatic beat_t make_beat(logic [31:0] d, bit v, bit f, bit dr, bit l);
		beat_t b;
		b.data    = v ? d : '0;
		b.dvalid  = v;
		b.fnd     = f;
		b.dropped = dr;
		b.cnt     = 5'(shadow_q.size());
		b.empty   = shadow_q.size() == 0;
		b.full    = shadow_q.size() >= DEPTH;
		b.lst     = l;
		return b;
	endfunction

	function automatic void queue_beat(beat_t b);
		pending_beats.insert(pending_beats.size(), b);
	endfunction

	// Advance the shadow deque by one command and queue the beats it causes.
	task automatic predict_deque(logic [3:0] c, logic [31:0] din, logic [31:0] rot, logic asc);
		logic [31:0] v, t, snap[$];
		bit          valid, fnd, dropped;
		int          n, sh, i, j;
		longint      m;
		v = '0;
		valid = 0;
		fnd = 0;
		dropped = 0;
		n = shadow_q.size();
		case (c)
			OP_ADD_BACK, OP_ADD_FRONT: begin
				if (n >= DEPTH) dropped = 1;
				else if (c == OP_ADD_BACK) shadow_q.insert(n, din);
				else shadow_q.insert(0, din);
			end
			OP_TAKE_BACK, OP_TAKE_FRONT, OP_PEEK_BACK, OP_PEEK_FRONT: begin
				if (n != 0) begin
					valid = 1;
					case (c)
						OP_TAKE_BACK: begin
							v = shadow_q[n-1];
							shadow_q.delete(n-1);
						end
						OP_TAKE_FRONT: begin
							v = shadow_q[0];
							shadow_q.delete(0);
						end
						OP_PEEK_BACK:  v = shadow_q[n-1];
						default:       v = shadow_q[0];
					endcase
				end
			end
			OP_CLEAR: shadow_q.delete();
			OP_CONTAINS: foreach (shadow_q[k]) if (shadow_q[k] == din) fnd = 1;
			OP_REVERSE: shadow_q.reverse();
			OP_SORT: begin
				// stable insertion sort on signed values
				for (i = 1; i < n; i++) begin
					t = shadow_q[i];
					j = i;
					while (j > 0 && (asc ? $signed(shadow_q[j-1]) > $signed(t)
					                     : $signed(shadow_q[j-1]) < $signed(t))) begin
						shadow_q[j] = shadow_q[j-1];
						j--;
					end
					shadow_q[j] = t;
				end
			end
			OP_SWAP_ENDS: if (n >= 2) begin
				t = shadow_q[0];
				shadow_q[0] = shadow_q[n-1];
				shadow_q[n-1] = t;
			end
			OP_ROTATE: if (n != 0) begin
				m = longint'($signed(rot)) % n;
				if (m < 0) m += n;
				sh = int'(m);
				snap = shadow_q;
				for (i = 0; i < n; i++) shadow_q[i] = snap[(i + sh) % n];
			end
			OP_READ_ALL, OP_POP_ALL: begin
				if (n != 0) begin
					snap = shadow_q;
					if (c == OP_POP_ALL) shadow_q.delete();
					for (i = 0; i < n; i++)
						queue_beat(make_beat(snap[i], 1, 0, 0, i == n - 1));
					return;
				end
			end
			default: ;
		endcase
		queue_beat(make_beat(v, valid, fnd, dropped, 1));
	endtask

	// Drive a command, wait until it is taken; start stays high unless the sender idles.
	task automatic issue_command(logic [3:0] c, logic [31:0] din, logic [31:0] rot, logic asc);
		while (sender_idle_pct != 0 && $urandom_range(99) < sender_idle_pct) begin
			start <= 1'b0;
			@(posedge clk);
		end
		while (busy) @(posedge clk);
		start     <= 1'b1;
		op        <= c;
		data_in   <= din;
		rotate_by <= rot;
		ascending <= asc;
		@(posedge clk);
		while (busy) @(posedge clk);
		predict_deque(c, din, rot, asc);
	endtask

	// Check each strobed result against the oldest expected beat.
	always @(posedge clk) begin
		beat_t got, want;
		if (arst_n && result_valid) begin
			got = '{data_out, data_valid, found, push_dropped, count, is_empty, is_full, last};
			if (pending_beats.size() == 0) begin
				$display("%0t: unexpected result beat, expected none, actual %p", $time, got);
				errors++;
			end else begin
				want = pending_beats[0];
				pending_beats.delete(0);
				if (got !== want) begin
					$display("%0t: result mismatch, expected %p, actual %p", $time, want, got);
					errors++;
				end
			end
		end
	end

	// Watchdog: count cycles with no command or result accepted.
	always @(posedge clk) begin
		if ((start && !busy) || result_valid) idle_cycles <= 0;
		else idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("simulation failed");
			$finish;
		end
	end

	function automatic logic [31:0] rand_value();
		case ($urandom_range(5))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return $urandom_range(7) << 16;  // small, collide often for contains
			default: return $urandom;
		endcase
	endfunction

	function automatic row_t plain_row(logic [3:0] c, logic [31:0] d, logic [31:0] r, logic a);
		row_t rw;
		rw.op = c; rw.din = d; rw.rot = r; rw.asc = a; rw.typed = 0; rw.beat = '0;
		return rw;
	endfunction

	function automatic row_t typed_row(logic [3:0] c, logic [31:0] d, beat_t b);
		row_t rw;
		rw = plain_row(c, d, '0, 1'b0);
		rw.typed = 1;
		rw.beat = b;
		return rw;
	endfunction

	row_t directed_rows[$];
	logic [3:0] rop;

	function automatic void add_row(row_t rw);
		directed_rows.insert(directed_rows.size(), rw);
	endfunction

	initial begin
		// Directed table: empty and single-element cases typed in, the rest predicted.
		add_row(typed_row(OP_STATUS, '0, '{0, 0, 0, 0, 0, 1, 0, 1}));
		add_row(typed_row(OP_TAKE_BACK, '0, '{0, 0, 0, 0, 0, 1, 0, 1}));
		add_row(typed_row(OP_PEEK_FRONT, '0, '{0, 0, 0, 0, 0, 1, 0, 1}));
		add_row(typed_row(OP_READ_ALL, '0, '{0, 0, 0, 0, 0, 1, 0, 1}));
		add_row(typed_row(OP_ADD_BACK, 32'h8000_0000, '{0, 0, 0, 0, 1, 0, 0, 1}));
		add_row(typed_row(OP_PEEK_BACK, '0, '{32'h8000_0000, 1, 0, 0, 1, 0, 0, 1}));
		add_row(plain_row(OP_ADD_FRONT, 32'h7FFF_FFFF, '0, 0));
		add_row(plain_row(OP_SWAP_ENDS, '0, '0, 0));
		add_row(plain_row(OP_CONTAINS, 32'h7FFF_FFFF, '0, 0));
		add_row(plain_row(OP_CONTAINS, 32'h0001_0000, '0, 0));
		for (int i = 0; i < 15; i++)
			add_row(plain_row(OP_ADD_BACK, 32'hFFFF_FFFF - i * 32'h1234_5679, '0, 0));
		add_row(plain_row(OP_ADD_FRONT, 32'h5555_AAAA, '0, 0));  // full: dropped
		add_row(plain_row(OP_SORT, '0, '0, 1));
		add_row(plain_row(OP_SORT, '0, '0, 0));
		add_row(plain_row(OP_REVERSE, '0, '0, 0));
		add_row(plain_row(OP_ROTATE, '0, 32'h8000_0000, 0));
		add_row(plain_row(OP_ROTATE, '0, 32'h7FFF_FFFF, 0));
		add_row(plain_row(OP_READ_ALL, '0, '0, 0));
		add_row(plain_row(OP_TAKE_FRONT, '0, '0, 0));
		add_row(plain_row(OP_POP_ALL, '0, '0, 0));
		add_row(plain_row(OP_RESERVED, '0, '0, 0));  // unused code acts as status

		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (directed_rows[k]) begin
			issue_command(directed_rows[k].op, directed_rows[k].din,
			              directed_rows[k].rot, directed_rows[k].asc);
			// Replace the prediction with the typed beat where one is given.
			if (directed_rows[k].typed) pending_beats[$] = directed_rows[k].beat;
		end
		issue_command(OP_CLEAR, '0, '0, 0);

		// Random phases: no idling, sender idle chance 56 percent, receiver phase (it
		// cannot stall, so no idling), then sender idle chance 14 percent.
		for (int ph = 0; ph < 4; ph++) begin
			sender_idle_pct = (ph == 1) ? 56 : (ph == 3) ? 14 : 0;
			for (int k = 0; k < 55; k++) begin
				// Favor pushes so the deque fills and hits the full flag.
				case ($urandom_range(9))
					0, 1, 2: rop = OP_ADD_BACK;
					3:       rop = OP_ADD_FRONT;
					default: rop = 4'($urandom_range(15));
				endcase
				issue_command(rop, rand_value(), $urandom, 1'($urandom_range(1)));
			end
		end
		start <= 1'b0;

		while (pending_beats.size() != 0) @(posedge clk);
		repeat (20) @(posedge clk);
		if (errors == 0) $display("simulation ok");
		else $display("simulation failed");
		$finish;
	end
endmodule
